// File: hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package lrupr_pkg;

  // Fixed widths of the port fields.
  localparam int PageWidth  = 16;
  localparam int CountWidth = 4;
  localparam int FaultWidth = 32;
  localparam int CfgWidth   = 4;

  // Defaults for the top-level parameters.
  localparam int DefaultMaxFrames = 8;
  localparam int DefaultPageBits  = 16;

  // Reset value of the frames-in-use register.
  localparam logic [CfgWidth-1:0] FramesReset = CfgWidth'(3);

  // The fault counter holds at this value.
  localparam logic [FaultWidth-1:0] FaultMax = '1;

  // One result item as it travels from the update logic to the result register.
  typedef struct packed {
    logic                  hit;
    logic                  evicted_valid;
    logic [PageWidth-1:0]  evicted_page;
    logic [CountWidth-1:0] resident_count;
    logic [FaultWidth-1:0] fault_total;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrupr_in_stage.sv
// Input register of the LRU page replacement block.
// Holds one page reference until the update stage consumes it; uses lrupr_pkg.
`default_nettype none

module lrupr_in_stage (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [lrupr_pkg::PageWidth-1:0]  page_number_i,
  input  wire logic                             out_free_i,
  output      logic                             fire_o,
  output      logic [lrupr_pkg::PageWidth-1:0]  page_o
);

  logic                            valid_q, valid_d;
  logic [lrupr_pkg::PageWidth-1:0] page_q;
  logic                            accept;

  // The held item moves on when the result register can take its result.
  assign fire_o     = valid_q && out_free_i;
  assign in_stall_o = valid_q && !fire_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign page_o     = page_q;

  // Occupancy of the input register.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is captured on every input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrupr_core.sv
// Recency list, occupancy, fault counter and the frames-in-use register.
// Does the whole lookup and list update for one reference; uses lrupr_pkg.
`default_nettype none

module lrupr_core #(
  parameter int MAX_FRAMES = lrupr_pkg::DefaultMaxFrames,
  parameter int PAGE_BITS  = lrupr_pkg::DefaultPageBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lrupr_pkg::CfgWidth-1:0]   cfg_wdata_i,
  input  wire logic                             fire_i,
  input  wire logic [lrupr_pkg::PageWidth-1:0]  page_i,
  output      lrupr_pkg::result_t               result_o
);

  // Pages are compared on their low PAGE_BITS bits; the port carries at most 16.
  localparam int StoreBits = (PAGE_BITS < lrupr_pkg::PageWidth) ? PAGE_BITS
                                                                 : lrupr_pkg::PageWidth;
  localparam int OccW = $clog2(MAX_FRAMES + 1);
  localparam int IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CmpW = (OccW > lrupr_pkg::CfgWidth) ? OccW : lrupr_pkg::CfgWidth;

  logic [StoreBits-1:0]             list_q [MAX_FRAMES];
  logic [StoreBits-1:0]             list_d [MAX_FRAMES];
  logic [StoreBits-1:0]             nbr    [MAX_FRAMES];
  logic [OccW-1:0]                  occ_q, occ_d;
  logic [lrupr_pkg::FaultWidth-1:0] fault_q, fault_d;
  logic [lrupr_pkg::CfgWidth-1:0]   frames_q;

  logic [StoreBits-1:0]  page;
  logic [MAX_FRAMES-1:0] match;
  logic [IdxW-1:0]       pos;
  logic                  hit;
  logic [OccW-1:0]       cap;
  logic                  full;
  logic                  do_shift;
  logic [OccW-1:0]       shift_from;
  logic [OccW-1:0]       occ_last;

  // Each entry's upper neighbor; the top entry has none and keeps itself.
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_nbr
    if (g < MAX_FRAMES - 1) begin : g_up
      assign nbr[g] = list_q[g + 1];
    end else begin : g_top
      assign nbr[g] = list_q[g];
    end
  end

  // Lookup across all resident entries and the resulting list update.
  always_comb begin
    page = StoreBits'(page_i);

    // Resident pages are distinct, so at most one entry matches and its
    // index is the OR of the matching indices.
    pos = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = (OccW'(i) < occ_q) && (list_q[i] == page);
      if (match[i]) begin
        pos = pos | IdxW'(i);
      end
    end
    hit = |match;

    // Capacity is the register clamped to one through MAX_FRAMES.
    if (frames_q == '0) begin
      cap = OccW'(1);
    end else if (CmpW'(frames_q) > CmpW'(MAX_FRAMES)) begin
      cap = OccW'(MAX_FRAMES);
    end else begin
      cap = OccW'(frames_q);
    end
    full = (occ_q >= cap);

    // A hit and an eviction both close the gap and put the page on top;
    // an eviction closes the gap left by the least recent entry.
    do_shift   = hit || full;
    shift_from = hit ? OccW'(pos) : '0;
    occ_last   = occ_q - OccW'(1);

    for (int i = 0; i < MAX_FRAMES; i++) begin
      list_d[i] = list_q[i];
      if (do_shift) begin
        if (OccW'(i) == occ_last) begin
          list_d[i] = page;
        end else if ((OccW'(i) >= shift_from) && (OccW'(i + 1) < occ_q)) begin
          list_d[i] = nbr[i];
        end
      end else if (OccW'(i) == occ_q) begin
        list_d[i] = page;
      end
    end

    occ_d = do_shift ? occ_q : occ_q + OccW'(1);

    // Faults count up and hold at the maximum.
    fault_d = fault_q;
    if (!hit && (fault_q != lrupr_pkg::FaultMax)) begin
      fault_d = fault_q + lrupr_pkg::FaultWidth'(1);
    end

    result_o.hit            = hit;
    result_o.evicted_valid  = !hit && full;
    result_o.evicted_page   = (!hit && full) ? lrupr_pkg::PageWidth'(list_q[0]) : '0;
    result_o.resident_count = lrupr_pkg::CountWidth'(occ_d);
    result_o.fault_total    = fault_d;
  end

  // Control state and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      fault_q  <= '0;
      frames_q <= lrupr_pkg::FramesReset;
    end else begin
      if (fire_i) begin
        occ_q   <= occ_d;
        fault_q <= fault_d;
      end
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
    end
  end

  // Recency list entries; entries at or above the occupancy are never read.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        list_q[i] <= list_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrupr_out_stage.sv
// Result register of the LRU page replacement block.
// Holds one result until the receiver takes it; uses lrupr_pkg.
`default_nettype none

module lrupr_out_stage (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire lrupr_pkg::result_t               result_i,
  output      logic                             out_free_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             hit_o,
  output      logic                             evicted_valid_o,
  output      logic [lrupr_pkg::PageWidth-1:0]  evicted_page_o,
  output      logic [lrupr_pkg::CountWidth-1:0] resident_count_o,
  output      logic [lrupr_pkg::FaultWidth-1:0] fault_total_o
);

  logic               valid_q, valid_d;
  lrupr_pkg::result_t res_q;

  // The register can load when empty or when its result leaves this cycle.
  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign hit_o            = res_q.hit;
  assign evicted_valid_o  = res_q.evicted_valid;
  assign evicted_page_o   = res_q.evicted_page;
  assign resident_count_o = res_q.resident_count;
  assign fault_total_o    = res_q.fault_total;

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_replacement.sv
// Top level of the fully associative LRU page replacement block.
// Instantiates lrupr_in_stage, lrupr_core and lrupr_out_stage; uses lrupr_pkg.
//
// Usage:
//   Input channel: in_valid_i, in_stall_o and page_number_i. One page
//   reference is transferred at a clock edge with in_valid_i high and
//   in_stall_o low.
//   Output channel: out_valid_o, out_stall_i and the result fields. One
//   result is transferred at an edge with out_valid_o high and out_stall_i low.
//   Configuration: cfg_we_i writes cfg_wdata_i into frames_in_use at once;
//   write it only while no reference is in flight.
//   Path: a reference waits in the input register, then its result is loaded
//   into the result register. Throughput: one reference per cycle while
//   out_stall_i is low; the lookup and list update are combinational between
//   the two registers, so the next reference sees the updated list.
//   Reset: clears both stage valids, the occupancy and the fault count, and
//   sets frames_in_use to 3. The list entries need no clearing.
//   Stall: while out_stall_i holds a result, the next reference waits in the
//   input register and in_stall_o rises once that register is full.
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::DefaultMaxFrames,
  parameter int PAGE_BITS  = lrupr_pkg::DefaultPageBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lrupr_pkg::CfgWidth-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [lrupr_pkg::PageWidth-1:0]  page_number_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             hit_o,
  output      logic                             evicted_valid_o,
  output      logic [lrupr_pkg::PageWidth-1:0]  evicted_page_o,
  output      logic [lrupr_pkg::CountWidth-1:0] resident_count_o,
  output      logic [lrupr_pkg::FaultWidth-1:0] fault_total_o
);

  logic                            out_free;
  logic                            fire;
  logic [lrupr_pkg::PageWidth-1:0] page;
  lrupr_pkg::result_t              res;

  // Input register.
  lrupr_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .page_number_i (page_number_i),
    .out_free_i    (out_free),
    .fire_o        (fire),
    .page_o        (page)
  );

  // Lookup and list update.
  lrupr_core #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .page_i      (page),
    .result_o    (res)
  );

  // Result register.
  lrupr_out_stage u_out_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (fire),
    .result_i         (res),
    .out_free_o       (out_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .resident_count_o (resident_count_o),
    .fault_total_o    (fault_total_o)
  );

`ifndef SYNTHESIS
  // The input side only stalls behind a result that the receiver holds.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.hit) |-> !res.evicted_valid)
    else $error("hit reported an eviction");

  // Without an eviction the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !res.evicted_valid) |-> (res.evicted_page == '0))
    else $error("evicted page not zero without an eviction");

  // A loaded result appears on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_o && (hit_o == $past(res.hit))))
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// File: tb/lru_page_replacement_test.sv
// Self-checking testbench for the LRU page replacement block.
// Drives page references, predicts every result from its own LRU list and compares.
// Depends on lrupr_pkg and lru_page_replacement from hw/rtl.
module lru_page_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxFrames = lrupr_pkg::DefaultMaxFrames;
  localparam int PageW     = lrupr_pkg::PageWidth;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lrupr_pkg::CfgWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PageW-1:0] page_number_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic evicted_valid_o;
  logic [PageW-1:0] evicted_page_o;
  logic [lrupr_pkg::CountWidth-1:0] resident_count_o;
  logic [lrupr_pkg::FaultWidth-1:0] fault_total_o;

  lru_page_replacement u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .page_number_i    (page_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .resident_count_o (resident_count_o),
    .fault_total_o    (fault_total_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pages waiting to be sent and results still owed by the block.
  logic [PageW-1:0] pages_to_send[$];
  lrupr_pkg::result_t results_due[$];

  // Our own copy of the block's state.
  logic [PageW-1:0] lru_order[MaxFrames];
  int unsigned resident_pages;
  logic [31:0] fault_tally;
  logic [3:0] frames_cfg;

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic page_taken = 1'b0;
  logic [PageW-1:0] working_set[16];

  // Applies one page reference to the predicted LRU list and returns the result.
  function automatic lrupr_pkg::result_t lru_reference(input logic [PageW-1:0] page);
    lrupr_pkg::result_t r;
    int unsigned cap;
    int unsigned pos;
    int unsigned i;
    bit found;
    r = '0;
    found = 1'b0;
    pos = 0;
    cap = frames_cfg;
    if (cap < 1) cap = 1;
    if (cap > MaxFrames) cap = MaxFrames;
    for (i = 0; i < resident_pages; i++) begin
      if (!found && lru_order[i] == page) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      for (i = pos; i + 1 < resident_pages; i++) lru_order[i] = lru_order[i+1];
      lru_order[resident_pages-1] = page;
    end else begin
      if (resident_pages >= cap) begin
        // Full, or the frame count was lowered: only the oldest page leaves.
        r.evicted_valid = 1'b1;
        r.evicted_page = lru_order[0];
        for (i = 0; i + 1 < resident_pages; i++) lru_order[i] = lru_order[i+1];
        lru_order[resident_pages-1] = page;
      end else begin
        lru_order[resident_pages] = page;
        resident_pages++;
      end
      if (fault_tally != lrupr_pkg::FaultMax) fault_tally++;
    end
    r.hit = found;
    r.resident_count = resident_pages[3:0];
    r.fault_total = fault_tally;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Monitor: checks each result transfer, then predicts for each reference transfer.
  always @(posedge clk_i) begin
    lrupr_pkg::result_t want;
    if (!rst_ni) begin
      resident_pages = 0;
      fault_tally = '0;
      frames_cfg = lrupr_pkg::FramesReset;
      page_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: expected no result, got hit %0b count %0d",
                   $time, hit_o, resident_count_o);
        end else begin
          want = results_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid_o));
          check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page_o));
          check_field("resident_count", 32'(want.resident_count),
                      32'(resident_count_o));
          check_field("fault_total", want.fault_total, fault_total_o);
        end
      end
      if (in_valid_i && !in_stall_o)
        results_due.insert(results_due.size(), lru_reference(page_number_i));
      page_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i) frames_cfg = cfg_wdata_i;
    end
  end

  // Driver: holds a page until it is transferred, then offers the next one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !page_taken) begin
        in_valid_i <= 1'b1;
      end else if (pages_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        page_number_i <= pages_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Adds one page to the end of the send queue.
  task automatic queue_page(input logic [PageW-1:0] page);
    pages_to_send.insert(pages_to_send.size(), page);
  endtask

  // Waits until nothing is queued or in flight, plus the pipeline latency.
  // The check runs at the rising edge, where the driven inputs are stable.
  task automatic wait_idle();
    @(posedge clk_i);
    while (!(pages_to_send.size() == 0 && !in_valid_i && results_due.size() == 0))
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_frames(input logic [3:0] frames);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= frames;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queues random references: mostly from a small working set so hits happen,
  // the rest spread over the whole page range.
  task automatic send_random(input int count, input int span);
    int k;
    @(posedge clk_i);
    working_set[0] = '0;
    working_set[1] = '1;
    for (k = 2; k < 16; k++) working_set[k] = PageW'($urandom_range(16'hFFFF));
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 75)
        queue_page(working_set[4'($urandom_range(span - 1))]);
      else
        queue_page(PageW'($urandom_range(16'hFFFF)));
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of three frames: hits at each list position and evictions.
    @(posedge clk_i);
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    queue_page(16'h0005);
    queue_page(16'h1234);
    queue_page(16'h0005);
    queue_page(16'h0005);
    queue_page(16'h1234);
    queue_page(16'hFFFF);

    // All eight frames: fill, evict the oldest, then hit inside the list.
    set_frames(4'd8);
    @(posedge clk_i);
    queue_page(16'h8001);
    queue_page(16'h8002);
    queue_page(16'h8003);
    queue_page(16'h8004);
    queue_page(16'h8005);
    queue_page(16'h8006);
    queue_page(16'h8007);
    queue_page(16'h8008);
    queue_page(16'h7FFF);
    queue_page(16'h8004);

    // Frame count lowered below occupancy: occupancy must not shrink.
    set_frames(4'd1);
    @(posedge clk_i);
    queue_page(16'hAAAA);
    queue_page(16'h5555);
    queue_page(16'h5555);

    // Zero frames behaves as one frame.
    set_frames(4'd0);
    @(posedge clk_i);
    queue_page(16'h0F0F);
    queue_page(16'hF0F0);

    // Frames above the maximum, no idling on either side.
    set_frames(4'd15);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(100, 12);

    set_frames(4'd9);
    send_idle_pct = 87;
    stall_pct = 0;
    send_random(100, 10);

    set_frames(4'd4);
    send_idle_pct = 0;
    stall_pct = 87;
    send_random(100, 6);

    set_frames(4'd2);
    send_idle_pct = 36;
    stall_pct = 36;
    send_random(100, 4);

    // Long hold-off on the result side while references keep coming.
    set_frames(4'd8);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_requests++;
    send_random(60, 12);

    // Sender pauses mid-phase until every result is back.
    set_frames(4'd5);
    send_idle_pct = 36;
    stall_pct = 36;
    send_random(75, 8);
    wait_idle();
    send_random(75, 8);

    set_frames(4'd1);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(50, 3);

    wait_idle();
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
